/* rtl/nfs_pkg.sv */
package nfs_pkg;

	localparam int IN_W = 31;
	localparam int VAL_W = IN_W + 1;
	localparam int PROD_W = VAL_W + 3;
	localparam int OUT_W = 32;
	localparam int CFG_W = 3;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int NUM_RADICES = 4;

	localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(2);
	localparam logic [CFG_W-1:0] LIMIT_MIN = CFG_W'(1);
	localparam logic [CFG_W-1:0] LIMIT_MAX = CFG_W'(NUM_RADICES);

	localparam logic REG_LIMIT = 1'b0;

	typedef logic [1:0] radix_sel_t;
	localparam radix_sel_t RADIX_2 = 2'd0;
	localparam radix_sel_t RADIX_3 = 2'd1;
	localparam radix_sel_t RADIX_5 = 2'd2;
	localparam radix_sel_t RADIX_7 = 2'd3;

	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic              fits;
		logic              below;
	} unit_res_t;

	function automatic logic [PROD_W-1:0] mul_radix(input logic [VAL_W-1:0] x,
		input radix_sel_t sel);
		logic [PROD_W-1:0] xe;
		logic [PROD_W-1:0] r;
		xe = PROD_W'(x);
		unique case (sel)
			RADIX_2: r = xe << 1;
			RADIX_3: r = (xe << 1) + xe;
			RADIX_5: r = (xe << 2) + xe;
			RADIX_7: r = (xe << 3) - xe;
			default: r = xe;
		endcase
		return r;
	endfunction

endpackage

/* rtl/nfs_radix_unit.sv */
module nfs_radix_unit (
	input  nfs_pkg::radix_sel_t        sel,
	input  logic [nfs_pkg::VAL_W-1:0] operand,
	input  logic [nfs_pkg::VAL_W-1:0] bound,
	input  logic [nfs_pkg::VAL_W-1:0] target,
	output nfs_pkg::unit_res_t         res
);
	import nfs_pkg::*;

	logic [PROD_W-1:0] prod;

	assign prod = mul_radix(operand, sel);

	always_comb begin
		res.prod  = prod;
		res.fits  = prod <= PROD_W'(bound);
		res.below = operand < target;
	end

endmodule

/* rtl/nfs_seq.sv */
module nfs_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nfs_pkg::IN_W-1:0]  target,
	input  logic [nfs_pkg::CFG_W-1:0] limit,
	input  logic                       done_ready,
	output logic                       busy,
	output logic                       done_valid,
	output logic [nfs_pkg::VAL_W-1:0] best
);
	import nfs_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POW  = 3'd1;
	localparam logic [2:0] ST_T7   = 3'd2;
	localparam logic [2:0] ST_T5   = 3'd3;
	localparam logic [2:0] ST_T3   = 3'd4;
	localparam logic [2:0] ST_T2   = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]       state_q;
	logic [VAL_W-1:0] n_q, bound_q, best_q, p2_q, p3_q, p5_q, cur_q;
	logic             f2_q, f3_q, f5_q, f7_q;

	radix_sel_t       sel;
	logic [VAL_W-1:0] operand;
	unit_res_t        ur;
	logic [VAL_W-1:0] prod;
	logic [2:0]       used;
	logic [CFG_W-1:0] lim;
	logic             take;

	always_comb begin
		unique case (state_q)
			ST_POW: begin
				sel = RADIX_2;
				operand = bound_q;
			end
			ST_T5: begin
				sel = RADIX_5;
				operand = p5_q;
			end
			ST_T3: begin
				sel = RADIX_3;
				operand = p3_q;
			end
			ST_T2: begin
				sel = RADIX_2;
				operand = p2_q;
			end
			default: begin
				sel = RADIX_7;
				operand = cur_q;
			end
		endcase
	end

	nfs_radix_unit u_unit (
		.sel    (sel),
		.operand(operand),
		.bound  (bound_q),
		.target (n_q),
		.res    (ur)
	);

	assign prod = ur.prod[VAL_W-1:0];
	assign used = 3'(f2_q) + 3'(f3_q) + 3'(f5_q) + 3'(f7_q);

	always_comb begin
		priority if (limit < LIMIT_MIN) begin
			lim = LIMIT_MIN;
		end else if (limit > LIMIT_MAX) begin
			lim = LIMIT_MAX;
		end else begin
			lim = limit;
		end
	end

	assign take = !ur.below && (cur_q < best_q) && (3'(used) <= 3'(lim));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start) state_q <= ST_POW;
				ST_POW:  if (!ur.below) state_q <= ST_T7;
				ST_T7:   if (!(ur.below && ur.fits)) state_q <= ST_T5;
				ST_T5:   state_q <= (ur.below && ur.fits) ? ST_T7 : ST_T3;
				ST_T3:   state_q <= (ur.below && ur.fits) ? ST_T7 : ST_T2;
				ST_T2:   state_q <= (ur.below && ur.fits) ? ST_T7 : ST_DONE;
				ST_DONE: if (done_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					n_q <= (target == '0) ? VAL_W'(1) : VAL_W'(target);
					bound_q <= VAL_W'(1);
				end
			end
			ST_POW: begin
				if (ur.below) begin
					bound_q <= prod;
				end else begin
					best_q <= bound_q;
					p2_q <= VAL_W'(1);
					p3_q <= VAL_W'(1);
					p5_q <= VAL_W'(1);
					cur_q <= VAL_W'(1);
					{f2_q, f3_q, f5_q, f7_q} <= 4'b0000;
				end
			end
			ST_T7: begin
				if (take) best_q <= cur_q;
				if (ur.below && ur.fits) begin
					cur_q <= prod;
					f7_q <= 1'b1;
				end
			end
			ST_T5: begin
				if (ur.below && ur.fits) begin
					p5_q <= prod;
					cur_q <= prod;
					f5_q <= 1'b1;
					f7_q <= 1'b0;
				end
			end
			ST_T3: begin
				if (ur.below && ur.fits) begin
					p3_q <= prod;
					p5_q <= prod;
					cur_q <= prod;
					f3_q <= 1'b1;
					{f5_q, f7_q} <= 2'b00;
				end
			end
			ST_T2: begin
				if (ur.below && ur.fits) begin
					p2_q <= prod;
					p3_q <= prod;
					p5_q <= prod;
					cur_q <= prod;
					f2_q <= 1'b1;
					{f3_q, f5_q, f7_q} <= 3'b000;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != ST_IDLE;
	assign done_valid = state_q == ST_DONE;
	assign best = best_q;

endmodule

/* rtl/nfs_regs.sv */
module nfs_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nfs_pkg::ADDR_W-1:0] paddr,
	input  logic [nfs_pkg::DATA_W-1:0] pwdata,
	output logic [nfs_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output logic [nfs_pkg::CFG_W-1:0]  limit
);
	import nfs_pkg::*;

	logic [CFG_W-1:0] limit_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_LIMIT) ? DATA_W'(limit_q) : '0;
	assign limit = limit_q;

endmodule

/* rtl/next_fft_size_unit.sv */
// Channel    Handshake                 Payload
// request    req_valid / req_stall     target_size  [30:0]
// response   rsp_valid / rsp_stall     fft_size     [31:0]
// config     APB psel/penable/pwrite   max_distinct_radices at byte address 0
//
// One transaction first finds the power-of-two bound by doubling from 1, then visits
// the candidate lengths of the radix-7/5/3/2 walk and steps back over exhausted loop
// levels, all through the single radix multiplier.
// req_stall is high from acceptance until the result is moved to the output register.
// A result waiting under rsp_stall holds; the next request may already be accepted.
// arst_n clears the sequencer, the output valid and sets the radix limit to 2.
module next_fft_size_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [nfs_pkg::IN_W-1:0]   target_size,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output logic [nfs_pkg::OUT_W-1:0]  fft_size,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nfs_pkg::ADDR_W-1:0] paddr,
	input  logic [nfs_pkg::DATA_W-1:0] pwdata,
	output logic [nfs_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import nfs_pkg::*;

	logic [CFG_W-1:0] limit;
	logic             busy, done_valid, done_ready;
	logic [VAL_W-1:0] best;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	nfs_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limit  (limit)
	);

	nfs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && !busy),
		.target    (target_size),
		.limit     (limit),
		.done_ready(done_ready),
		.busy      (busy),
		.done_valid(done_valid),
		.best      (best)
	);

	assign done_ready = !out_valid_q || !rsp_stall;
	assign req_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_valid && done_ready) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) out_q <= OUT_W'(best);
	end

	assign rsp_valid = out_valid_q;
	assign fft_size = out_q;

endmodule

/* rtl/nfs_checker.sv */
module nfs_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic                        rsp_valid,
	input logic                        rsp_stall,
	input logic [nfs_pkg::OUT_W-1:0]  fft_size
);
	import nfs_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(fft_size))
		else $error("response changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request channel open right after acceptance");

	a_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> fft_size != '0)
		else $error("zero transform length");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!fft_size[OUT_W-1] || fft_size[OUT_W-2:0] == '0))
		else $error("transform length above power-of-two bound");

endmodule

bind next_fft_size_unit nfs_checker u_nfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.fft_size (fft_size)
);

/* sim/next_fft_size_unit_test.sv */
`timescale 1ns / 1ps

module next_fft_size_unit_test;
	import nfs_pkg::*;

	localparam logic [ADDR_W-1:0] LIMIT_ADDR = ADDR_W'(4 * REG_LIMIT);
	localparam logic [ADDR_W-1:0] UNUSED_ADDR = ADDR_W'(4);
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int DRAIN_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS = 157;

	logic clk;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [IN_W-1:0] target_size = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [OUT_W-1:0] fft_size;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	logic [CFG_W-1:0] radix_limit = LIMIT_RESET;
	logic [OUT_W-1:0] expected_sizes[$];
	int mismatches = 0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	int pressure_asked = 0;
	int pressure_served = 0;
	int hold_left = 0;

	next_fft_size_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.target_size(target_size),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.fft_size(fft_size),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(64'd800_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic logic [OUT_W-1:0] next_smooth_size(input logic [IN_W-1:0] req,
		input logic [CFG_W-1:0] lim);
		logic [63:0] n;
		logic [63:0] bound;
		logic [63:0] best;
		logic [63:0] p2, p3, p5, p7;
		int allowed;
		int used;
		n = 64'(req);
		if (n == 0)
			n = 1;
		allowed = int'(lim);
		if (allowed < int'(LIMIT_MIN))
			allowed = int'(LIMIT_MIN);
		if (allowed > int'(LIMIT_MAX))
			allowed = int'(LIMIT_MAX);
		bound = 1;
		while (bound < n)
			bound = bound << 1;
		best = bound;
		for (p2 = 1; p2 <= bound; p2 = p2 * 2)
			for (p3 = p2; p3 <= bound; p3 = p3 * 3)
				for (p5 = p3; p5 <= bound; p5 = p5 * 5)
					for (p7 = p5; p7 <= bound; p7 = p7 * 7) begin
						used = int'(p2 != 1) + int'(p3 != p2) + int'(p5 != p3)
							+ int'(p7 != p5);
						if (p7 >= n && p7 < best && used <= allowed)
							best = p7;
					end
		return best[OUT_W-1:0];
	endfunction

	function automatic logic [IN_W-1:0] rand_target();
		logic [IN_W-1:0] v;
		int pick;
		int w;
		v = IN_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 8) begin
			v = (IN_W'(1) << $urandom_range(0, IN_W - 1)) + IN_W'($urandom_range(0, 2))
				- IN_W'(1);
		end else if (pick >= 16) begin
			w = $urandom_range(1, 14);
			v = v & ((IN_W'(1) << w) - IN_W'(1));
		end
		return v;
	endfunction

	task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on %s: expected %0d, got %0d", what, want, got);
	endtask

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) begin
			if (expected_sizes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected fft_size transaction: %0d", fft_size);
			end else begin
				if (fft_size !== expected_sizes[0])
					note_mismatch("fft_size", expected_sizes[0], fft_size);
				void'(expected_sizes.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (pressure_asked != pressure_served) begin
			pressure_served = pressure_asked;
			hold_left = HOLD_OFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (sink_idle_on) begin
			rsp_stall <= ($urandom_range(99) < 30);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	task automatic send_request(input logic [IN_W-1:0] n);
		if (src_idle_on && $urandom_range(99) < 30) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		target_size <= n;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		expected_sizes.push_back(next_smooth_size(n, radix_limit));
	endtask

	task automatic wait_drained();
		int waited;
		waited = 0;
		req_valid <= 1'b0;
		while (expected_sizes.size() > 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
		logic [DATA_W-1:0] wdata;
		wdata = DATA_W'($urandom);
		wdata[CFG_W-1:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == LIMIT_ADDR)
			radix_limit = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check_limit();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= LIMIT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== DATA_W'(radix_limit))
			note_mismatch("max_distinct_radices readback", DATA_W'(radix_limit), prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic test_reset_value();
		apb_check_limit();
	endtask

	task automatic test_directed();
		send_request(IN_W'(0));
		send_request(IN_W'(1));
		send_request(IN_W'(2));
		send_request(IN_W'(3));
		send_request(IN_W'(5));
		send_request(IN_W'(7));
		send_request(IN_W'(11));
		send_request(IN_W'(211));
		send_request(IN_W'(1000));
		send_request(IN_W'(1025));
		send_request(IN_W'(1) << (IN_W - 1));
		send_request((IN_W'(1) << (IN_W - 1)) + IN_W'(1));
		send_request('1);
		send_request('1 - IN_W'(1));
		wait_drained();
	endtask

	task automatic test_radix_limits();
		int lim;
		for (lim = 0; lim < (1 << CFG_W); lim++) begin
			apb_write(LIMIT_ADDR, CFG_W'(lim));
			apb_check_limit();
			send_request(IN_W'(1000));
			send_request(rand_target());
			send_request(rand_target());
			wait_drained();
		end
		apb_write(UNUSED_ADDR, CFG_W'($urandom));
		apb_check_limit();
		send_request('1);
		send_request(IN_W'(100));
		wait_drained();
	endtask

	task automatic test_random();
		int phase;
		int i;
		for (phase = 0; phase < 5; phase++) begin
			case (phase)
				0: apb_write(LIMIT_ADDR, LIMIT_MIN);
				1: apb_write(LIMIT_ADDR, LIMIT_MAX);
				default: apb_write(LIMIT_ADDR, CFG_W'($urandom));
			endcase
			src_idle_on = (phase != 2);
			sink_idle_on = (phase != 2);
			for (i = 0; i < PHASE_ITEMS; i++)
				send_request(rand_target());
			wait_drained();
		end
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		int i;
		apb_write(LIMIT_ADDR, LIMIT_RESET);
		src_idle_on = 1'b0;
		pressure_asked++;
		for (i = 0; i < 24; i++)
			send_request(IN_W'($urandom_range(1, 4096)));
		src_idle_on = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_value();
		test_directed();
		test_radix_limits();
		test_random();
		test_backpressure();
		wait_drained();
		mismatches += expected_sizes.size();
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
rtl/nfs_pkg.sv
rtl/nfs_radix_unit.sv
rtl/nfs_seq.sv
rtl/nfs_regs.sv
rtl/next_fft_size_unit.sv
rtl/nfs_checker.sv
sim/next_fft_size_unit_test.sv
